// ===== hw/rtl/sht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_pkg
// Shared constants, codes and types of the spatial hash table.
// ----------------------------------------------------------------------------
package sht_pkg;

	localparam int TABLE_SIZE = 32768;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int COORD_BITS = 16;

	localparam int MODE_W  = 2;
	localparam int COORD_W = 16;
	localparam int INDEX_W = 15;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 15;

	localparam logic [31:0] PRIME_X = 32'd73856093;
	localparam logic [31:0] PRIME_Y = 32'd19349663;
	localparam logic [31:0] PRIME_Z = 32'd83492791;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} key_t;

	typedef struct packed {
		logic               used;
		key_t               key;
		logic [INDEX_W-1:0] idx;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/sht_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_if
// Valid/ready channels for requests into and results out of the table.
// ----------------------------------------------------------------------------
interface sht_req_if;
	logic                        valid;
	logic                        ready;
	logic [sht_pkg::MODE_W-1:0]  mode;
	logic [sht_pkg::COORD_W-1:0] cell_x;
	logic [sht_pkg::COORD_W-1:0] cell_y;
	logic [sht_pkg::COORD_W-1:0] cell_z;
	logic [sht_pkg::INDEX_W-1:0] item_index;

	modport source (output valid, mode, cell_x, cell_y, cell_z, item_index, input ready);
	modport sink (input valid, mode, cell_x, cell_y, cell_z, item_index, output ready);
endinterface

interface sht_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [sht_pkg::STAT_W-1:0]  status;
	logic [sht_pkg::INDEX_W-1:0] found_index;
	logic [sht_pkg::SLOT_W-1:0]  slot;

	modport source (output valid, status, found_index, slot, input ready);
	modport sink (input valid, status, found_index, slot, output ready);
endinterface

// ===== hw/rtl/sht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sht_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/sht_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_hash
// Home slot of a grid cell: prime products masked and registered, then XORed.
// ----------------------------------------------------------------------------
module sht_hash (
	input  logic                       clk,
	input  logic                       load,
	input  sht_pkg::key_t              key,
	output logic [sht_pkg::ADDR_W-1:0] home
);

	logic [31:0] ext_x, ext_y, ext_z;
	logic [31:0] prod_x, prod_y, prod_z;
	logic [sht_pkg::ADDR_W-1:0] px_s1, py_s1, pz_s1;

	assign ext_x = 32'($signed(key.x[sht_pkg::COORD_BITS-1:0]));
	assign ext_y = 32'($signed(key.y[sht_pkg::COORD_BITS-1:0]));
	assign ext_z = 32'($signed(key.z[sht_pkg::COORD_BITS-1:0]));

	assign prod_x = ext_x * sht_pkg::PRIME_X;
	assign prod_y = ext_y * sht_pkg::PRIME_Y;
	assign prod_z = ext_z * sht_pkg::PRIME_Z;

	always_ff @(posedge clk) begin
		if (load) begin
			px_s1 <= prod_x[sht_pkg::ADDR_W-1:0];
			py_s1 <= prod_y[sht_pkg::ADDR_W-1:0];
			pz_s1 <= prod_z[sht_pkg::ADDR_W-1:0];
		end
	end

	assign home = px_s1 ^ py_s1 ^ pz_s1;

endmodule

// ===== hw/rtl/spatial_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_table
// Open-addressing hash table of 3-D grid cells with linear probing.
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance, insert and lookup pass
// through S_PROBE, then read one slot per cycle from the single table memory
// in S_CHECK until the probe ends (at least one slot), then go to S_PUT.
// An insert into a full table and an unused mode go straight to S_PUT. Clear
// sweeps the memory one slot per cycle in S_CLEAR, then goes to S_PUT.
// After reset the same sweep runs over all TABLE_SIZE slots before the
// first request is accepted. A finished result waits in the output register
// while the next request is accepted; S_PUT waits until the output register
// can take the result, so the table waits until that register drains.
// ----------------------------------------------------------------------------
module spatial_hash_table (
	input  logic      clk,
	input  logic      arst_n,
	sht_req_if.sink   req,
	sht_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_PROBE,
		S_CHECK,
		S_CLEAR,
		S_PUT
	} state_t;

	state_t state_q;

	logic [sht_pkg::MODE_W-1:0]  mode_q;
	sht_pkg::key_t               key_q;
	logic [sht_pkg::INDEX_W-1:0] idx_q;
	logic [sht_pkg::ADDR_W-1:0]  addr_q;
	logic [sht_pkg::ADDR_W-1:0]  probe_cnt_q;
	logic [sht_pkg::CNT_W-1:0]   used_count_q;

	logic [sht_pkg::STAT_W-1:0]  res_status_q;
	logic [sht_pkg::INDEX_W-1:0] res_found_q;
	logic [sht_pkg::ADDR_W-1:0]  res_slot_q;

	logic                        out_valid_q;
	logic [sht_pkg::STAT_W-1:0]  out_status_q;
	logic [sht_pkg::INDEX_W-1:0] out_found_q;
	logic [sht_pkg::SLOT_W-1:0]  out_slot_q;

	sht_pkg::key_t              req_key;
	logic                       req_xfer;
	logic [sht_pkg::ADDR_W-1:0] home;
	logic [sht_pkg::ADDR_W-1:0] next_addr;

	logic                        ram_we;
	logic [sht_pkg::ADDR_W-1:0]  ram_waddr;
	sht_pkg::entry_t             ram_wdata;
	logic [sht_pkg::ADDR_W-1:0]  ram_raddr;
	logic [sht_pkg::ENTRY_W-1:0] ram_rdata;
	sht_pkg::entry_t             rd_entry;
	logic                        key_match;
	logic                        sweep_last;

	assign req_key   = '{x: req.cell_x, y: req.cell_y, z: req.cell_z};
	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;

	sht_hash u_hash (
		.clk  (clk),
		.load (req_xfer),
		.key  (req_key),
		.home (home)
	);

	sht_ram #(
		.DEPTH (sht_pkg::TABLE_SIZE),
		.WIDTH (sht_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry   = sht_pkg::entry_t'(ram_rdata);
	assign next_addr  = addr_q + 1'b1;
	assign sweep_last = (addr_q == {sht_pkg::ADDR_W{1'b1}});
	assign key_match  =
		(rd_entry.key.x[sht_pkg::COORD_BITS-1:0] == key_q.x[sht_pkg::COORD_BITS-1:0]) &&
		(rd_entry.key.y[sht_pkg::COORD_BITS-1:0] == key_q.y[sht_pkg::COORD_BITS-1:0]) &&
		(rd_entry.key.z[sht_pkg::COORD_BITS-1:0] == key_q.z[sht_pkg::COORD_BITS-1:0]);

	always_comb begin
		ram_raddr = (state_q == S_PROBE) ? home : next_addr;
		ram_waddr = addr_q;
		ram_we    = 1'b0;
		ram_wdata = '0;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_CHECK: begin
				if (mode_q == sht_pkg::MODE_INSERT && !rd_entry.used) begin
					ram_we    = 1'b1;
					ram_wdata = '{used: 1'b1, key: key_q, idx: idx_q};
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			addr_q       <= '0;
			used_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (rsp.ready && state_q != S_PUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					addr_q <= next_addr;
					if (sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_xfer) begin
						mode_q      <= req.mode;
						key_q       <= req_key;
						idx_q       <= req.item_index;
						addr_q      <= '0;
						res_found_q <= '0;
						res_slot_q  <= '0;
						priority case (req.mode)
							sht_pkg::MODE_INSERT: begin
								if (used_count_q >= sht_pkg::CNT_W'(sht_pkg::TABLE_SIZE)) begin
									res_status_q <= sht_pkg::STATUS_FULL;
									state_q      <= S_PUT;
								end else begin
									state_q <= S_PROBE;
								end
							end
							sht_pkg::MODE_LOOKUP: begin
								state_q <= S_PROBE;
							end
							sht_pkg::MODE_CLEAR: begin
								state_q <= S_CLEAR;
							end
							default: begin
								res_status_q <= sht_pkg::STATUS_MISS;
								state_q      <= S_PUT;
							end
						endcase
					end
				end
				S_PROBE: begin
					addr_q      <= home;
					probe_cnt_q <= '0;
					state_q     <= S_CHECK;
				end
				S_CHECK: begin
					if (mode_q == sht_pkg::MODE_INSERT) begin
						if (!rd_entry.used) begin
							used_count_q <= used_count_q + 1'b1;
							res_status_q <= sht_pkg::STATUS_OK;
							res_slot_q   <= addr_q;
							state_q      <= S_PUT;
						end else begin
							addr_q <= next_addr;
						end
					end else begin
						priority if (!rd_entry.used) begin
							res_status_q <= sht_pkg::STATUS_MISS;
							state_q      <= S_PUT;
						end else if (key_match) begin
							res_status_q <= sht_pkg::STATUS_OK;
							res_found_q  <= rd_entry.idx;
							res_slot_q   <= addr_q;
							state_q      <= S_PUT;
						end else if (probe_cnt_q == {sht_pkg::ADDR_W{1'b1}}) begin
							res_status_q <= sht_pkg::STATUS_MISS;
							state_q      <= S_PUT;
						end else begin
							addr_q      <= next_addr;
							probe_cnt_q <= probe_cnt_q + 1'b1;
						end
					end
				end
				S_CLEAR: begin
					addr_q <= next_addr;
					if (sweep_last) begin
						used_count_q <= '0;
						res_status_q <= sht_pkg::STATUS_OK;
						state_q      <= S_PUT;
					end
				end
				S_PUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= res_found_q;
						out_slot_q   <= sht_pkg::SLOT_W'(res_slot_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_found_q;
	assign rsp.slot        = out_slot_q;

endmodule

// ===== verif/spatial_hash_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_table_checker
// Watches the request and result channels of the spatial hash table. Keeps a
// shadow copy of the table, works out the outcome of every accepted request,
// and compares each result transfer field by field with the oldest outcome
// still owed.
// ----------------------------------------------------------------------------
module spatial_hash_table_checker
	import sht_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sht_req_if   req,
	sht_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [INDEX_W-1:0] found_index;
		logic [SLOT_W-1:0]  slot;
	} outcome_t;

	localparam int REPORT_LIMIT = 25;

	logic               occupied [TABLE_SIZE];
	key_t               stored_key [TABLE_SIZE];
	logic [INDEX_W-1:0] stored_index [TABLE_SIZE];
	int unsigned        fill;
	outcome_t           owed_outcomes [$];

	task automatic flag_mismatch(input string what);
		if (errors < REPORT_LIMIT) begin
			$display("%0t mismatch: %s", $realtime, what);
		end
		errors++;
	endtask

	function automatic logic [ADDR_W-1:0] home_slot_of(input key_t k);
		logic [31:0] sx, sy, sz, h;
		sx = {{(32-COORD_W){k.x[COORD_W-1]}}, k.x};
		sy = {{(32-COORD_W){k.y[COORD_W-1]}}, k.y};
		sz = {{(32-COORD_W){k.z[COORD_W-1]}}, k.z};
		h = (sx * PRIME_X) ^ (sy * PRIME_Y) ^ (sz * PRIME_Z);
		return h[ADDR_W-1:0];
	endfunction

	function automatic outcome_t apply_request(input logic [MODE_W-1:0] m, input key_t k,
			input logic [INDEX_W-1:0] idx);
		outcome_t res;
		logic [ADDR_W-1:0] s;
		int n;
		res = '0;
		res.status = STATUS_MISS;
		s = home_slot_of(k);
		case (m)
		MODE_INSERT: begin
			res.status = STATUS_FULL;
			if (fill < TABLE_SIZE) begin
				n = 0;
				while (occupied[s] && n < TABLE_SIZE) begin
					s++;
					n++;
				end
				if (n < TABLE_SIZE) begin
					occupied[s] = 1'b1;
					stored_key[s] = k;
					stored_index[s] = idx;
					fill++;
					res.status = STATUS_OK;
					res.slot = SLOT_W'(s);
				end
			end
		end
		MODE_LOOKUP: begin
			for (n = 0; n < TABLE_SIZE && occupied[s]; n++) begin
				if (stored_key[s] == k) begin
					res.status = STATUS_OK;
					res.found_index = stored_index[s];
					res.slot = SLOT_W'(s);
					break;
				end
				s++;
			end
		end
		MODE_CLEAR: begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				occupied[i] = 1'b0;
			end
			fill = 0;
			res.status = STATUS_OK;
		end
		default: begin
			res.status = STATUS_MISS;
		end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		key_t k;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				occupied[i] = 1'b0;
			end
			fill = 0;
			owed_outcomes.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (owed_outcomes.size() == 0) begin
					flag_mismatch($sformatf("result status %0d slot %0d with no request owed",
						rsp.status, rsp.slot));
				end else begin
					want = owed_outcomes.pop_front();
					if (rsp.status !== want.status) begin
						flag_mismatch($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
					end
					if (rsp.found_index !== want.found_index) begin
						flag_mismatch($sformatf("found_index %0d, expected %0d",
							rsp.found_index, want.found_index));
					end
					if (rsp.slot !== want.slot) begin
						flag_mismatch($sformatf("slot %0d, expected %0d", rsp.slot, want.slot));
					end
				end
			end
			if (req.valid && req.ready) begin
				k.x = req.cell_x;
				k.y = req.cell_y;
				k.z = req.cell_z;
				owed_outcomes.push_back(apply_request(req.mode, k, req.item_index));
			end
			pending = owed_outcomes.size();
		end
	end

endmodule

// ===== verif/spatial_hash_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_table_test
// Top of the spatial hash table testbench. Drives a directed set of inserts,
// lookups, clears and unused-mode requests, then a long random mix built
// around keys already stored and keys sharing a home slot, with bursty
// requests, a stalling result side and one long result hold-off. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module spatial_hash_table_test;
	import sht_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 12;
	localparam int RANDOM_ITEMS    = 1650;
	localparam int MAX_CLEARS      = 5;
	localparam int KEY_POOL_SIZE   = 512;
	localparam int HOLD_OFF_AFTER  = 300;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 40;
	localparam int CYCLE_LIMIT     = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sht_req_if req_ch();
	sht_rsp_if rsp_ch();

	int errors;
	int pending;
	int cycles = 0;
	int results_seen = 0;
	int burst_left = 0;
	int mode_count [4] = '{default: 0};
	int status_count [4] = '{default: 0};
	key_t stored_keys [$];

	spatial_hash_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	spatial_hash_table_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, pending);
			$display("** spatial_hash_table: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				mode_count[req_ch.mode]++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				status_count[rsp_ch.status]++;
				results_seen++;
			end
		end
	end

	function automatic key_t grid_key(input logic [COORD_W-1:0] x, y, z);
		key_t k;
		k.x = x;
		k.y = y;
		k.z = z;
		return k;
	endfunction

	function automatic key_t random_key();
		return grid_key(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
	endfunction

	// flip sign bits only: the low bits of each product, and so the home slot, stay put
	function automatic key_t same_home_key(input key_t k);
		logic [2:0] flips;
		flips = 3'($urandom_range(1, 7));
		k.x[COORD_W-1] ^= flips[0];
		k.y[COORD_W-1] ^= flips[1];
		k.z[COORD_W-1] ^= flips[2];
		return k;
	endfunction

	function automatic key_t pooled_key();
		return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
	endfunction

	function automatic logic [COORD_W-1:0] x_for_last_slot();
		logic [31:0] prod;
		for (int v = 0; v < TABLE_SIZE; v++) begin
			prod = 32'(v) * PRIME_X;
			if (&prod[ADDR_W-1:0]) begin
				return COORD_W'(v);
			end
		end
		return '0;
	endfunction

	task automatic send(input logic [MODE_W-1:0] m, input key_t k,
			input logic [INDEX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		req_ch.mode = m;
		req_ch.cell_x = k.x;
		req_ch.cell_y = k.y;
		req_ch.cell_z = k.z;
		req_ch.item_index = idx;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic store(input key_t k, input logic [INDEX_W-1:0] idx);
		send(MODE_INSERT, k, idx);
		stored_keys.push_back(k);
		if (stored_keys.size() > KEY_POOL_SIZE) begin
			void'(stored_keys.pop_front());
		end
	endtask

	initial begin : result_side
		int regime;
		int phase_left;
		logic [7:0] stall_pattern;
		bit held;
		rsp_ch.ready = 1'b0;
		regime = 0;
		phase_left = 0;
		stall_pattern = 8'hff;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_OFF_AFTER) begin
				held = 1'b1;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			if (phase_left == 0) begin
				regime = $urandom_range(0, 3);
				phase_left = $urandom_range(16, 96);
				stall_pattern = 8'($urandom) | 8'h01;
			end
			phase_left--;
			stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
			case (regime)
			0: rsp_ch.ready = 1'b1;
			1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
			2: rsp_ch.ready = ($urandom_range(0, 2) == 0);
			default: rsp_ch.ready = stall_pattern[0];
			endcase
		end
	end

	initial begin : requests
		logic [COORD_W-1:0] wx;
		logic [COORD_W-1:0] top_bit;
		key_t k;
		int counted;
		int clears_left;
		int pick;
		int flavor;

		req_ch.valid = 1'b0;
		req_ch.mode = MODE_INSERT;
		req_ch.cell_x = '0;
		req_ch.cell_y = '0;
		req_ch.cell_z = '0;
		req_ch.item_index = '0;
		wx = x_for_last_slot();
		top_bit = '0;
		top_bit[COORD_W-1] = 1'b1;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		send(MODE_LOOKUP, grid_key('0, '0, '0), '0);
		send(MODE_INSERT, grid_key('0, '0, '0), '0);
		send(MODE_INSERT, grid_key(~top_bit, ~top_bit, ~top_bit), '1);
		send(MODE_INSERT, grid_key(top_bit, top_bit, top_bit), INDEX_W'(1));
		send(MODE_INSERT, grid_key(top_bit, '0, '0), INDEX_W'(2));
		send(MODE_INSERT, grid_key('0, '0, '0), INDEX_W'(3));
		send(MODE_LOOKUP, grid_key('0, '0, '0), '0);
		send(MODE_LOOKUP, grid_key(top_bit, '0, '0), '0);
		send(MODE_LOOKUP, grid_key('0, top_bit, top_bit), '1);
		send(MODE_LOOKUP, grid_key(~top_bit, ~top_bit, ~top_bit), '0);
		send(MODE_LOOKUP, grid_key(top_bit, top_bit, top_bit), '0);
		send(MODE_INSERT, grid_key(wx, '0, '0), INDEX_W'(15'h5555));
		send(MODE_INSERT, grid_key(wx ^ top_bit, '0, '0), INDEX_W'(15'h2aaa));
		send(MODE_LOOKUP, grid_key(wx ^ top_bit, '0, '0), '0);
		send(MODE_LOOKUP, grid_key(wx, top_bit, '0), '0);
		send(MODE_INSERT, grid_key('1, '1, '1), INDEX_W'(4));
		send(MODE_LOOKUP, grid_key('1, '1, '1), '0);
		send(MODE_UNUSED, grid_key('1, '1, '1), '1);
		send(MODE_LOOKUP, grid_key(COORD_W'(1), '1, COORD_W'(1)), '0);
		send(MODE_CLEAR, grid_key('1, '1, '1), '1);
		send(MODE_LOOKUP, grid_key('0, '0, '0), '0);
		send(MODE_INSERT, grid_key('0, '0, '0), INDEX_W'(15'h1234));
		send(MODE_LOOKUP, grid_key('0, '0, '0), '0);

		counted = 0;
		clears_left = MAX_CLEARS;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 999);
			flavor = $urandom_range(0, 4);
			if (pick < 4 && clears_left > 0) begin
				send(MODE_CLEAR, random_key(), INDEX_W'($urandom));
				stored_keys.delete();
				clears_left--;
				counted++;
			end else if (pick < 34) begin
				send(MODE_UNUSED, random_key(), INDEX_W'($urandom));
			end else if (pick < 460) begin
				if (stored_keys.size() == 0 || flavor < 2) begin
					k = random_key();
				end else if (flavor < 4) begin
					k = same_home_key(pooled_key());
				end else begin
					k = pooled_key();
				end
				store(k, INDEX_W'($urandom));
				counted++;
			end else begin
				if (stored_keys.size() == 0 || flavor == 4) begin
					k = random_key();
				end else if (flavor == 3) begin
					k = same_home_key(pooled_key());
				end else begin
					k = pooled_key();
				end
				send(MODE_LOOKUP, k, INDEX_W'($urandom));
				counted++;
			end
		end
		req_ch.valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("requests: %0d inserts, %0d lookups, %0d clears, %0d in the unused mode",
			mode_count[MODE_INSERT], mode_count[MODE_LOOKUP], mode_count[MODE_CLEAR],
			mode_count[MODE_UNUSED]);
		$display("results: %0d stored or found, %0d not found, %0d full; %0d mismatches",
			status_count[STATUS_OK], status_count[STATUS_MISS], status_count[STATUS_FULL],
			errors);
		if (errors == 0) begin
			$display("** spatial_hash_table: PASSED **");
		end else begin
			$display("** spatial_hash_table: FAILED **");
		end
		$finish;
	end

endmodule
